@@ rtl/gb3_pkg.sv @@
package gb3_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned FW_W          = 9;   // frame_width register
  localparam int unsigned FH_W          = 12;  // frame_height register
  localparam int unsigned CNT_W         = 13;  // holds any effective width up to 4096
  localparam int unsigned ROW_W         = 13;  // input row count, runs a little past height
  localparam int unsigned SUM_W         = 12;  // 16 * 255 fits
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned MAX_WIDTH_DEF = 256;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_W    = 2;

  localparam logic [FW_W-1:0] FW_RESET = 9'd160;
  localparam logic [FH_W-1:0] FH_RESET = 12'd120;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-item control carried from the address stage to the filter stage
  typedef struct packed {
    logic valid;
    logic emit;
    logic border;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } result_t;

endpackage

@@ rtl/gb3_ram.sv @@
module gb3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Read-first: a read of the entry being written returns the old contents
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/gb3_ctrl.sv @@
module gb3_ctrl #(
  parameter int unsigned MaxWidth = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gb3_pkg::FW_W-1:0]      frame_width_i,
  input  logic [gb3_pkg::FH_W-1:0]      frame_height_i,
  input  logic                          restart_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [gb3_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic                          flush_i,
  output logic [$clog2(MaxWidth)-1:0]   rd_addr_o,
  output logic                          take_o,
  output gb3_pkg::flags_t               s1_flags_o,
  output logic [$clog2(MaxWidth)-1:0]   s1_addr_o,
  output logic [gb3_pkg::PIX_W-1:0]     s1_pix_o
);
  import gb3_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth);

  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [AW-1:0]    out_col_q, out_col_d;
  logic [FH_W-1:0]  out_row_q, out_row_d;

  logic [CNT_W-1:0] w_eff;
  logic [FH_W-1:0]  h_eff;
  logic             active, accept, emit, border, last;
  logic             out_col_end, out_row_end;

  flags_t           s1_flags_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;

  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = CNT_W'(1);
    end else if (CNT_W'(frame_width_i) > CNT_W'(MaxWidth)) begin
      w_eff = CNT_W'(MaxWidth);
    end else begin
      w_eff = CNT_W'(frame_width_i);
    end
    h_eff = (frame_height_i == '0) ? FH_W'(1) : frame_height_i;
  end

  // Past the last input row every item counts as padding
  assign active = row_q < ROW_W'(h_eff);
  assign accept = in_valid_i && !in_stall_i;
  assign take_o = accept && !(active && flush_i);

  assign emit        = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
  assign out_col_end = CNT_W'(out_col_q) == (w_eff - CNT_W'(1));
  assign out_row_end = out_row_q == (h_eff - FH_W'(1));
  assign border      = (out_col_q == '0) || out_col_end || (out_row_q == '0) || out_row_end;
  assign last        = out_col_end && out_row_end;

  assign rd_addr_o = col_q;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (restart_i) begin
      col_d     = '0;
      row_d     = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (take_o) begin
      if (CNT_W'(col_q) + CNT_W'(1) >= w_eff) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
      if (emit) begin
        if (last) begin
          col_d     = '0;
          row_d     = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (CNT_W'(out_col_q) + CNT_W'(1) >= w_eff) begin
          out_col_d = '0;
          out_row_d = out_row_q + FH_W'(1);
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s1_flags_q <= '0;
    end else begin
      col_q             <= col_d;
      row_q             <= row_d;
      out_col_q         <= out_col_d;
      out_row_q         <= out_row_d;
      s1_flags_q.valid  <= take_o;
      s1_flags_q.emit   <= take_o && emit;
      s1_flags_q.border <= border;
      s1_flags_q.last   <= take_o && emit && last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= active ? pixel_in_i : '0;
    end
  end

  assign s1_flags_o = s1_flags_q;
  assign s1_addr_o  = s1_addr_q;
  assign s1_pix_o   = s1_pix_q;

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(col_q) < w_eff)
    else $error("column count beyond row width");

  a_last_needs_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_flags_q.last |-> (s1_flags_q.emit && s1_flags_q.valid && $past(take_o)))
    else $error("last marker on an item that gives no result");

endmodule

@@ rtl/gb3_filter.sv @@
module gb3_filter #(
  parameter int unsigned MaxWidth = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gb3_pkg::flags_t               s1_flags_i,
  input  logic [$clog2(MaxWidth)-1:0]   s1_addr_i,
  input  logic [gb3_pkg::PIX_W-1:0]     s1_pix_i,
  input  logic                          take_i,
  input  logic [$clog2(MaxWidth)-1:0]   rd_addr_i,
  input  logic [2*gb3_pkg::PIX_W-1:0]   rd_data_i,
  output logic                          wr_en_o,
  output logic [$clog2(MaxWidth)-1:0]   wr_addr_o,
  output logic [2*gb3_pkg::PIX_W-1:0]   wr_data_o,
  output logic                          push_o,
  output gb3_pkg::result_t              push_data_o
);
  import gb3_pkg::*;

  logic [PIX_W-1:0]   win_q [6];
  logic               fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic [2*PIX_W-1:0] line_data;
  logic [PIX_W-1:0]   top, mid;
  logic [SUM_W-1:0]   sum;

  // Entry read in the same cycle as it was written: take the registered write data
  assign line_data   = fwd_q ? fwd_data_q : rd_data_i;
  assign top         = line_data[2*PIX_W-1:PIX_W];
  assign mid         = line_data[PIX_W-1:0];

  assign wr_en_o   = s1_flags_i.valid;
  assign wr_addr_o = s1_addr_i;
  assign wr_data_o = {mid, s1_pix_i};

  assign sum = SUM_W'(win_q[0]) + SUM_W'(top) + SUM_W'(win_q[2]) + SUM_W'(s1_pix_i)
             + ((SUM_W'(win_q[3]) + SUM_W'(win_q[1]) + SUM_W'(mid) + SUM_W'(win_q[5]))
                << 1)
             + (SUM_W'(win_q[4]) << 2);

  assign push_o           = s1_flags_i.valid && s1_flags_i.emit;
  assign push_data_o.pix  = s1_flags_i.border ? win_q[4] : sum[SUM_W-1:4];
  assign push_data_o.last = s1_flags_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= take_i && s1_flags_i.valid && (rd_addr_i == s1_addr_i);
      if (s1_flags_i.valid) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= s1_pix_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data_o;
  end

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> ($past(wr_en_o) && s1_flags_i.valid))
    else $error("forwarding without a preceding write");

endmodule

@@ rtl/gb3_fifo.sv @@
module gb3_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  gb3_pkg::result_t              push_data_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output gb3_pkg::result_t              out_data_o,
  output logic [gb3_pkg::FIFO_PTR_W:0]  count_o
);
  import gb3_pkg::*;

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q, count_d;
  logic                  pop;

  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_d     = count_q + (FIFO_PTR_W+1)'(push_i) - (FIFO_PTR_W+1)'(pop);
  assign count_o     = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < (FIFO_PTR_W+1)'(FIFO_DEPTH)))
    else $error("result buffer overflow");

endmodule

@@ rtl/gaussian_blur_3x3_unit.sv @@
// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, sum >> 4) on an 8-bit grey stream.
// Input channel: in_valid_i / in_stall_o with pixel_in_i and flush_i, raster order.
// Output channel: out_valid_o / out_stall_i with pixel_out_o and last_of_frame_o.
// An item moves on a rising edge with valid high and stall low.
// Border pixels (first/last row and column) pass through unchanged.
// Results lag the stream by frame_width+1 items; after a frame's last pixel,
// frame_width+1 flush items push out the tail, the final pixel marked by
// last_of_frame_o. Flush items before the frame is complete are dropped.
// Throughput: one item per clock while in_stall_o is low. An item is taken
// into the filter stage with its line-store read, then filtered into the result
// buffer; the result shows on out_valid_o and leaves when out_stall_i is low.
// The rate is set by the single read-modify-write of the line store per item;
// back-to-back hits on one entry (one-pixel rows) go through a forwarding path.
// A stalled receiver fills the four-item result buffer; in_stall_o rises
// once results in flight reach the buffer depth, so nothing is lost.
// Reset: counters and window cleared, width 160, height 120. The line stores
// are not cleared; no result ever depends on an unwritten entry.
// APB: frame_width at 0x0, frame_height at 0x4; a write restarts the frame.
module gaussian_blur_3x3_unit #(
  parameter int unsigned MaxWidth = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel stream in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gb3_pkg::PIX_W-1:0]         pixel_in_i,
  input  logic                              flush_i,
  // filtered stream out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gb3_pkg::PIX_W-1:0]         pixel_out_o,
  output logic                              last_of_frame_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gb3_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gb3_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import gb3_pkg::*;

  localparam int unsigned AW = $clog2(MaxWidth);

  // Configuration registers
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            cfg_wr;
  cfg_reg_e        cfg_sel;

  // Stage links
  logic               take;
  flags_t             s1_flags;
  logic [AW-1:0]      rd_addr, s1_addr, wr_addr;
  logic [PIX_W-1:0]   s1_pix;
  logic [2*PIX_W-1:0] rd_data, wr_data;
  logic               wr_en;
  logic               push;
  result_t            push_data, out_data;
  logic [FIFO_PTR_W:0]   fifo_count;
  logic [FIFO_PTR_W+1:0] inflight;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // Results in flight: those in the buffer plus one in the filter stage.
  // Built from registers only, so stall does not ripple from the output side.
  assign inflight   = (FIFO_PTR_W+2)'(fifo_count)
                    + (FIFO_PTR_W+2)'(s1_flags.valid && s1_flags.emit);
  assign in_stall_o = inflight >= (FIFO_PTR_W+2)'(FIFO_DEPTH);

  gb3_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .restart_i      (cfg_wr),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .flush_i        (flush_i),
    .rd_addr_o      (rd_addr),
    .take_o         (take),
    .s1_flags_o     (s1_flags),
    .s1_addr_o      (s1_addr),
    .s1_pix_o       (s1_pix)
  );

  // Both line stores share one entry: upper byte two rows back, lower one row back
  gb3_ram #(
    .Width (2*PIX_W),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gb3_filter #(
    .MaxWidth (MaxWidth)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_flags_i  (s1_flags),
    .s1_addr_i   (s1_addr),
    .s1_pix_i    (s1_pix),
    .take_i      (take),
    .rd_addr_i   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_data_o (push_data)
  );

  gb3_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .count_o     (fifo_count)
  );

  assign pixel_out_o     = out_data.pix;
  assign last_of_frame_o = out_data.last;

endmodule
